### src/dre_pkg.sv
// Package for the DST rule evaluator: item, rule and configuration types,
// register indexes, and the small arithmetic helper shared by the design.
// No dependencies.
package dre_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam int DAYS_PER_WEEK = 7;
  localparam int LAST_WEEK     = 5;

  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic signed [26:0] DST_OFFSET_RESET = 27'sd3600000;

  typedef enum logic [1:0] {
    RULE_NONE     = 2'd0,
    RULE_JULIAN   = 2'd1,
    RULE_ABSOLUTE = 2'd2,
    RULE_RELATIVE = 2'd3
  } rule_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_RULE  = 3'd0,
    CFG_START_CLOCK = 3'd1,
    CFG_END_RULE    = 3'd2,
    CFG_END_CLOCK   = 3'd3,
    CFG_STD_OFFSET  = 3'd4,
    CFG_DST_OFFSET  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0] day;
    logic [2:0] week;
    logic [3:0] month;
    rule_kind_t kind;
  } rule_t;

  typedef struct packed {
    rule_t              start_rule;
    logic [26:0]        start_clock_ms;
    rule_t              end_rule;
    logic [26:0]        end_clock_ms;
    logic signed [26:0] std_offset_ms;
    logic signed [26:0] dst_offset_ms;
  } cfg_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  week_day;
    logic [8:0]  year_day;
    logic [26:0] clock_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [26:0] offset_ms;
    logic               is_dst;
  } out_item_t;

  // Remainder by seven of a nine-bit value; eight is one modulo seven, so the
  // octal digits are summed and folded.
  function automatic logic [2:0] mod7(input logic [8:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    if (t >= 4'(DAYS_PER_WEEK)) begin
      t = t - 4'(DAYS_PER_WEEK);
    end
    return t[2:0];
  endfunction

endpackage

### src/dre_cfg_regs.sv
// Configuration register file of the DST rule evaluator.
// Decodes writes by register index and presents all registers as one struct.
// Depends on dre_pkg.
module dre_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dre_pkg::CFG_DATA_W-1:0] cfg_data,
  output dre_pkg::cfg_t                 cfg
);
  import dre_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_RULE:  cfg_nxt.start_rule     = rule_t'(cfg_data[17:0]);
        CFG_START_CLOCK: cfg_nxt.start_clock_ms = cfg_data;
        CFG_END_RULE:    cfg_nxt.end_rule       = rule_t'(cfg_data[17:0]);
        CFG_END_CLOCK:   cfg_nxt.end_clock_ms   = cfg_data;
        CFG_STD_OFFSET:  cfg_nxt.std_offset_ms  = $signed(cfg_data);
        CFG_DST_OFFSET:  cfg_nxt.dst_offset_ms  = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_rule:     '0,
                 start_clock_ms: '0,
                 end_rule:       '0,
                 end_clock_ms:   '0,
                 std_offset_ms:  '0,
                 dst_offset_ms:  DST_OFFSET_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/dst_rule_evaluator.sv
// DST rule evaluator. For each date item (year, month, day, weekday, day of
// year, time of day) the block returns the local offset and a DST flag, using
// the configured start and end rules (julian, absolute or month.week.weekday,
// each with a time of day). It takes one item every clock cycle while the
// output is not stalled, through a three-stage pipeline (weekday and year/100,
// leap year and transition day, compare and select). A stalled output holds
// the pipeline, and a new item is still taken while any stage is empty.
// Registers must be written by the user through the cfg port only while no
// item is in flight; the block does not enforce this. Depends on dre_pkg and dre_cfg_regs.
module dst_rule_evaluator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dre_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dre_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dre_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dre_pkg::*;

  typedef struct packed {
    in_item_t   item;
    logic [2:0] first_wd;
    logic [5:0] q100;
  } s1_t;

  typedef struct packed {
    in_item_t   item;
    logic       leap;
    logic [5:0] tgt_start;
    logic [5:0] tgt_end;
  } s2_t;

  cfg_t cfg;

  logic      s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, out_valid_r, out_valid_nxt;
  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      out_ready, s2_ready, s1_ready;

  logic [2:0]  in_wd;
  logic [8:0]  fw_sum;
  logic [24:0] yprod;
  logic [11:0] rem100;
  logic [4:0]  mlen;
  logic        has_start, has_end, before_s, before_e, dst;

  dre_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Day of month of the week-th occurrence of the rule weekday, before the
  // month-length correction of the last-week case.
  function automatic logic [5:0] rel_target(input rule_t r, input logic [2:0] first_wd);
    logic [2:0] rwd;
    logic [2:0] w;
    logic [3:0] d;
    rwd = mod7(r.day);
    w = r.week;
    if (w == 3'd0) begin
      w = 3'd1;
    end else if (w > 3'(LAST_WEEK)) begin
      w = 3'(LAST_WEEK);
    end
    d = {1'b0, rwd} + 4'(DAYS_PER_WEEK) - {1'b0, first_wd};
    if (d >= 4'(DAYS_PER_WEEK)) begin
      d = d - 4'(DAYS_PER_WEEK);
    end
    return 6'd1 + 6'(d) + 6'({3'b0, 3'(w - 3'd1)} * 6'(DAYS_PER_WEEK));
  endfunction

  function automatic logic before_trans(input rule_t r, input logic [26:0] rclk,
                                        input in_item_t it, input logic leap,
                                        input logic [5:0] tpre, input logic [4:0] ml);
    logic signed [10:0] now_v;
    logic signed [10:0] tgt_v;
    logic [5:0]         rel_t;
    rel_t = (tpre > {1'b0, ml}) ? tpre - 6'(DAYS_PER_WEEK) : tpre;
    case (r.kind)
      RULE_ABSOLUTE: begin
        now_v = {2'b0, it.year_day};
        tgt_v = {2'b0, r.day};
      end
      RULE_JULIAN: begin
        now_v = {2'b0, it.year_day};
        if (it.month > 4'd2 && leap) begin
          now_v = now_v - 11'sd1;
        end
        tgt_v = {2'b0, r.day};
      end
      default: begin
        now_v = {6'b0, it.day};
        tgt_v = {5'b0, rel_t};
      end
    endcase
    if (now_v < tgt_v) begin
      return 1'b1;
    end else if (now_v > tgt_v) begin
      return 1'b0;
    end
    return it.clock_ms < rclk;
  endfunction

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Stage one: weekday of the first of the month and the year divided by 100.
  always_comb begin
    in_wd  = (in_item.week_day == 3'(DAYS_PER_WEEK)) ? 3'd0 : in_item.week_day;
    fw_sum = 9'(in_wd) + 9'd43 - 9'(in_item.day);
    yprod  = 25'(in_item.year) * 25'(DIV100_MUL);
    s1_v_nxt = s1_ready ? in_valid : s1_v_r;
    s1_nxt   = s1_r;
    if (s1_ready && in_valid) begin
      s1_nxt.item     = in_item;
      s1_nxt.first_wd = mod7(fw_sum);
      s1_nxt.q100     = 6'(yprod >> DIV100_SHIFT);
    end
  end

  // Stage two: leap year and the relative-rule target days.
  always_comb begin
    rem100   = s1_r.item.year - 12'({6'b0, s1_r.q100} * 12'd100);
    s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;
    s2_nxt   = s2_r;
    if (s2_ready && s1_v_r) begin
      s2_nxt.item      = s1_r.item;
      s2_nxt.leap      = (s1_r.item.year[1:0] == 2'd0) &&
                         ((rem100 != 12'd0) || (s1_r.q100[1:0] == 2'd0));
      s2_nxt.tgt_start = rel_target(cfg.start_rule, s1_r.first_wd);
      s2_nxt.tgt_end   = rel_target(cfg.end_rule, s1_r.first_wd);
    end
  end

  // Stage three: transition compares, month window and offset select.
  always_comb begin
    case (s2_r.item.month) inside
      4'd2:                    mlen = s2_r.leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
      default:                 mlen = 5'd31;
    endcase
    has_start = cfg.start_rule.kind != RULE_NONE;
    has_end   = cfg.end_rule.kind != RULE_NONE;
    before_s  = before_trans(cfg.start_rule, cfg.start_clock_ms, s2_r.item, s2_r.leap,
                             s2_r.tgt_start, mlen);
    before_e  = before_trans(cfg.end_rule, cfg.end_clock_ms, s2_r.item, s2_r.leap,
                             s2_r.tgt_end, mlen);
    if (!has_start) begin
      dst = 1'b0;
    end else if (s2_r.item.month < cfg.start_rule.month ||
                 (has_end && s2_r.item.month > cfg.end_rule.month)) begin
      dst = 1'b0;
    end else if (s2_r.item.month == cfg.start_rule.month) begin
      dst = !before_s;
    end else if (has_end && s2_r.item.month == cfg.end_rule.month) begin
      dst = before_e;
    end else begin
      dst = 1'b1;
    end
    out_valid_nxt = out_ready ? s2_v_r : out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_ready && s2_v_r) begin
      out_item_nxt.is_dst    = dst;
      out_item_nxt.offset_ms = dst ? cfg.dst_offset_ms : cfg.std_offset_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    out_item_r <= out_item_nxt;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_ready) |=> s2_v_r)
    else $error("item lost between stage one and stage two");

  a_leap_div4: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_r.leap) |-> (s2_r.item.year[1:0] == 2'd0))
    else $error("leap year flagged for a year not divisible by four");

  a_rel_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_r.tgt_start >= 6'd1 && s2_r.tgt_start <= 6'd35 &&
                s2_r.tgt_end >= 6'd1 && s2_r.tgt_end <= 6'd35))
    else $error("relative target day out of range");

endmodule
